@@ rtl/rbf_pkg.sv @@
// Shared types, codes and helpers of the row bitmap filter engine.
// Used by every module of the block; it depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

   localparam int ROWS_DEF   = 4096;
   localparam int CHUNK_BITS = 64;
   localparam int MAX_CHUNKS = 64;
   // Row and word address widths that cover the largest supported bitmap.
   localparam int ROW_AW     = 17;
   localparam int WORD_AW    = ROW_AW - 6;
   localparam int QDEPTH     = 2;

   localparam logic [3:0] F_INIT   = 4'd0;
   localparam logic [3:0] F_SET    = 4'd1;
   localparam logic [3:0] F_FILL   = 4'd2;
   localparam logic [3:0] F_GET    = 4'd3;
   localparam logic [3:0] F_AND    = 4'd4;
   localparam logic [3:0] F_MERGE  = 4'd5;
   localparam logic [3:0] F_ISECT  = 4'd6;
   localparam logic [3:0] F_APPEND = 4'd7;
   localparam logic [3:0] F_NONE   = 4'd8;
   localparam logic [3:0] F_COUNT  = 4'd9;
   localparam logic [3:0] F_OPT    = 4'd10;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_CAP   = 2'd2;

   typedef enum logic [3:0] {
      OP_ERR, OP_INIT, OP_FILL, OP_GET, OP_AND, OP_MERGE, OP_ISECT,
      OP_APPEND, OP_NONE, OP_COUNT, OP_OPT
   } op_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [12:0] position;
      logic [12:0] length;
      logic        bit_value;
      logic [63:0] data_word;
      logic        other_all_ones;
      logic        last_chunk;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        answer;
      logic [63:0] bits_out;
      logic [11:0] chunk_start;
      logic [12:0] ones_count;
      logic        final_result;
   } rsp_type;

   // One classified item as the back end carries it out.
   typedef struct packed {
      op_type              op;
      logic [1:0]          status;
      logic                bv;
      logic                other;
      logic                last;
      logic                toomany;
      logic [63:0]         data;
      logic [ROW_AW-1:0]   rstart;
      logic [ROW_AW-1:0]   rend;
      logic [11:0]         cstart;
      logic [6:0]          nchunk;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic scanning;
   } back_sts_type;

   function automatic logic [63:0] lowmask(input logic [6:0] n);
      return (n >= 7'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
   endfunction

endpackage

`default_nettype wire

@@ rtl/rbf_front.sv @@
// Front end: checks and classifies each accepted item into a command.
// Depends on rbf_pkg; holds the count of rows in use.
`timescale 1ns / 1ps
`default_nettype none

module rbf_front import rbf_pkg::*; #(
   parameter int ROWS = ROWS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req_item,
   output cmd_type      cmd
);

   localparam int RIW = $clog2(ROWS + 1);

   logic [RIW-1:0]    riu_ff, riu_in;
   logic [ROW_AW-1:0] pos_x, len_x, riu_x, nch;
   logic              in_range;

   assign pos_x    = ROW_AW'(req_item.position);
   assign len_x    = ROW_AW'(req_item.length);
   assign riu_x    = ROW_AW'(riu_ff);
   assign in_range = (pos_x + len_x) <= riu_x;
   assign nch      = (len_x + ROW_AW'(CHUNK_BITS - 1)) >> 6;

   always_comb begin
      cmd         = '0;
      cmd.op      = OP_ERR;
      cmd.status  = ST_RANGE;
      cmd.bv      = req_item.bit_value;
      cmd.other   = req_item.other_all_ones;
      cmd.last    = req_item.last_chunk;
      cmd.data    = req_item.data_word & lowmask(req_item.length[6:0]);
      cmd.rstart  = pos_x;
      cmd.rend    = pos_x + len_x;
      cmd.cstart  = req_item.position[11:0];
      cmd.toomany = nch > ROW_AW'(MAX_CHUNKS);
      cmd.nchunk  = nch[6:0];
      riu_in      = riu_ff;
      // Chunk operations with too many valid bits are refused first.
      if ((req_item.func >= F_AND) && (req_item.func <= F_APPEND) &&
          (len_x > ROW_AW'(CHUNK_BITS))) begin
         cmd.op = OP_ERR;
      end else begin
         unique case (req_item.func)
            F_INIT: begin
               if (len_x > ROW_AW'(ROWS)) begin
                  cmd.status = ST_CAP;
               end else begin
                  cmd.op     = OP_INIT;
                  cmd.rstart = '0;
                  cmd.rend   = len_x;
                  riu_in     = RIW'(len_x);
               end
            end
            F_SET: begin
               if (pos_x < riu_x) begin
                  cmd.op   = OP_FILL;
                  cmd.rend = pos_x + ROW_AW'(1);
               end
            end
            F_FILL:  if (in_range) cmd.op = OP_FILL;
            F_GET:   if (in_range) cmd.op = OP_GET;
            F_AND:   if (in_range) cmd.op = OP_AND;
            F_MERGE: if (in_range) cmd.op = OP_MERGE;
            F_ISECT: if (in_range) cmd.op = OP_ISECT;
            F_APPEND: begin
               if ((riu_x + len_x) > ROW_AW'(ROWS)) begin
                  cmd.status = ST_CAP;
               end else begin
                  cmd.op     = OP_APPEND;
                  cmd.rstart = riu_x;
                  cmd.rend   = riu_x + len_x;
                  cmd.cstart = riu_x[11:0];
                  riu_in     = RIW'(riu_x + len_x);
               end
            end
            F_NONE:  if (in_range) cmd.op = OP_NONE;
            F_COUNT: begin
               cmd.op     = OP_COUNT;
               cmd.rstart = '0;
               cmd.rend   = riu_x;
            end
            F_OPT: begin
               cmd.op     = OP_OPT;
               cmd.rstart = '0;
               cmd.rend   = riu_x;
            end
            default: cmd.op = OP_ERR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         riu_ff <= '0;
      end else if (accept) begin
         riu_ff <= riu_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/rbf_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on rbf_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module rbf_queue import rbf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         not_empty,
   output logic         full
);

   localparam int PW = $clog2(QDEPTH);

   cmd_type        slot_ff [QDEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]    cnt_ff, cnt_in;

   assign head      = slot_ff[rd_ff];
   assign not_empty = cnt_ff != '0;
   assign full      = cnt_ff == (PW+1)'(QDEPTH);

   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/rbf_back.sv @@
// Back end: holds the bitmap memory and the hint, sweeps the words of each
// command and produces the results. Depends on rbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbf_back import rbf_pkg::*; #(
   parameter int ROWS = ROWS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   output rsp_type      rsp_item,
   output back_sts_type sts
);

   localparam int WORDS = (ROWS + 63) / 64;
   localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [WORD_AW-1:0] WLAST_ALL = WORD_AW'(WORDS - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_INIT  = 5'b00100,
      S_RD    = 5'b01000,
      S_EXEC  = 5'b10000
   } state_type;

   logic [63:0] mem [WORDS];

   state_type          state_ff, state_in;
   logic [WORD_AW-1:0] w_ff, w_in, wlast_ff, wlast_in;
   cmd_type            cmd_ff, cmd_in;
   logic               pass2_ff, pass2_in, hint_ff, hint_in;
   logic               acc_all_ff, acc_all_in, acc_any_ff, acc_any_in;
   logic [ROW_AW-1:0]  cnt_ff, cnt_in;
   logic [63:0]        prev_ff, prev_in, rd_ff;
   logic [11:0]        cs_ff, cs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [WORD_AW-1:0] ws, we, hws, hwe;
   logic [5:0]         o, eo;
   logic [63:0]        m, wm, dw, wr_word, chunk, mem_wd;
   logic [127:0]       dsh, cat;
   logic               all_now, any_now, last_word, extract, mem_we;
   logic [ROW_AW-1:0]  cnt_now;
   logic [WIW-1:0]     mem_addr;

   assign ws  = cmd_ff.rstart[ROW_AW-1:6];
   assign we  = cmd_ff.rend[ROW_AW-1:6];
   assign o   = cmd_ff.rstart[5:0];
   assign eo  = cmd_ff.rend[5:0];
   assign hws = q_cmd.rstart[ROW_AW-1:6];
   assign hwe = q_cmd.rend[ROW_AW-1:6];

   // Mask of the rows of the current word that lie inside the range.
   always_comb begin
      m = '0;
      if ((w_ff >= ws) && (w_ff <= we)) begin
         m = ((w_ff == ws) ? ~lowmask({1'b0, o}) : '1) &
             ((w_ff == we) ? lowmask({1'b0, eo}) : '1);
      end
   end

   assign wm        = rd_ff & m;
   assign dsh       = {64'd0, cmd_ff.data} << o;
   assign dw        = (w_ff == ws) ? dsh[63:0] : dsh[127:64];
   assign cat       = {wm, prev_ff} >> o;
   assign chunk     = cat[63:0];
   assign all_now   = acc_all_ff & (&(rd_ff | ~m));
   assign any_now   = acc_any_ff | (|wm);
   assign cnt_now   = cnt_ff + ROW_AW'($countones(wm));
   assign last_word = w_ff == wlast_ff;
   assign extract   = pass2_ff || (cmd_ff.op == OP_AND);

   always_comb begin
      case (cmd_ff.op)
         OP_FILL:   wr_word = (rd_ff & ~m) | (cmd_ff.bv ? m : 64'd0);
         OP_MERGE:  wr_word = hint_ff ? rd_ff : (rd_ff | dw);
         OP_ISECT:  wr_word = hint_ff ? ((rd_ff & ~m) | dw) : (rd_ff & (~m | dw));
         OP_APPEND: wr_word = (rd_ff & ~m) | dw;
         default:   wr_word = rd_ff;
      endcase
   end

   always_comb begin
      mem_addr = (w_ff < WORD_AW'(WORDS)) ? w_ff[WIW-1:0] : '0;
      mem_wd   = '0;
      mem_we   = 1'b0;
      if (state_ff == S_INIT) begin
         mem_we = 1'b1;
         mem_wd = cmd_ff.bv ? m : 64'd0;
      end else if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_EXEC) begin
         mem_we = (cmd_ff.op == OP_FILL) || (cmd_ff.op == OP_MERGE) ||
                  (cmd_ff.op == OP_ISECT) || (cmd_ff.op == OP_APPEND);
         mem_wd = wr_word;
      end
      mem_we = mem_we && (w_ff < WORD_AW'(WORDS));
   end

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      wlast_in     = wlast_ff;
      cmd_in       = cmd_ff;
      pass2_in     = pass2_ff;
      hint_in      = hint_ff;
      acc_all_in   = acc_all_ff;
      acc_any_in   = acc_any_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      cs_in        = cs_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            if (w_ff == WLAST_ALL) state_in = S_IDLE;
            else w_in = w_ff + WORD_AW'(1);
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cmd_in     = q_cmd;
               pass2_in   = 1'b0;
               acc_all_in = 1'b1;
               acc_any_in = 1'b0;
               cnt_in     = '0;
               prev_in    = '0;
               cs_in      = q_cmd.cstart;
               if (q_cmd.op == OP_ERR) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = q_cmd.status;
                  rsp_in.final_result = 1'b1;
               end else if (q_cmd.op == OP_INIT) begin
                  w_in     = '0;
                  state_in = S_INIT;
               end else begin
                  w_in     = hws;
                  wlast_in = (q_cmd.op == OP_AND) ? hws + WORD_AW'(1) : hwe;
                  state_in = S_RD;
               end
            end
         end
         S_INIT: begin
            if (w_ff == WLAST_ALL) begin
               hint_in             = cmd_ff.bv;
               rsp_valid_in        = 1'b1;
               rsp_in.final_result = 1'b1;
               state_in            = S_IDLE;
            end else begin
               w_in = w_ff + WORD_AW'(1);
            end
         end
         S_RD: state_in = S_EXEC;
         S_EXEC: begin
            acc_all_in = all_now;
            acc_any_in = any_now;
            cnt_in     = cnt_now;
            prev_in    = wm;
            // A chunk is complete once the word after its first word is in.
            if (extract && (w_ff != ws)) begin
               rsp_valid_in        = 1'b1;
               rsp_in.chunk_start  = cs_ff;
               cs_in               = cs_ff + 12'd64;
               rsp_in.bits_out     = (cmd_ff.op == OP_AND) ?
                                     (hint_ff ? cmd_ff.data : (cmd_ff.data & chunk)) :
                                     chunk;
               rsp_in.final_result = last_word;
            end
            if (last_word) begin
               state_in = S_IDLE;
               if (!extract) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.final_result = 1'b1;
                  unique case (cmd_ff.op)
                     OP_GET: begin
                        if (hint_ff || all_now) begin
                           rsp_in.answer      = 1'b1;
                           rsp_in.chunk_start = cmd_ff.cstart;
                        end else if (cmd_ff.toomany) begin
                           rsp_in.status = ST_RANGE;
                        end else begin
                           rsp_valid_in = 1'b0;
                           pass2_in     = 1'b1;
                           w_in         = ws;
                           wlast_in     = ws + WORD_AW'(cmd_ff.nchunk);
                           state_in     = S_RD;
                        end
                     end
                     OP_MERGE: begin
                        rsp_in.chunk_start = cmd_ff.cstart;
                        if (cmd_ff.last) hint_in = hint_ff | cmd_ff.other;
                     end
                     OP_ISECT, OP_APPEND: begin
                        rsp_in.chunk_start = cmd_ff.cstart;
                        if (cmd_ff.last) hint_in = hint_ff & cmd_ff.other;
                     end
                     OP_NONE:  rsp_in.answer = !hint_ff && !any_now;
                     OP_COUNT: rsp_in.ones_count = cnt_now[12:0];
                     OP_OPT:   hint_in = all_now;
                     default: ;
                  endcase
               end
            end else begin
               w_in     = w_ff + WORD_AW'(1);
               state_in = S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         w_ff         <= '0;
         hint_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wlast_ff   <= wlast_in;
      cmd_ff     <= cmd_in;
      pass2_ff   <= pass2_in;
      acc_all_ff <= acc_all_in;
      acc_any_ff <= acc_any_in;
      cnt_ff     <= cnt_in;
      prev_ff    <= prev_in;
      cs_ff      <= cs_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      rd_ff <= mem[mem_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_ff;
   assign sts.clearing = state_ff == S_CLEAR;
   assign sts.scanning = (state_ff == S_RD) || (state_ff == S_EXEC);

endmodule

`default_nettype wire

@@ rtl/row_bitmap_filter_engine.sv @@
// Top level of the row bitmap filter engine: front end, command queue and
// back end. Depends on rbf_pkg, rbf_front, rbf_queue and rbf_back.
//
//   channel   ports                  handshake
//   request   start, busy, req_item  taken when start is high and busy is low
//   response  rsp_valid, rsp_item    one cycle per item, cannot be held off
//
// An item is checked and queued in the cycle it is taken; the back end then
// reads each bitmap word it touches, then modifies and writes it. Get range
// scans its words once and then may stream its chunks one at a time; init
// writes all ROWS/64 words, one per cycle; refused items answer in the cycle
// after they leave the queue. After reset a clearing pass zeroes the memory
// while busy is high. Busy is also high while the two-entry queue is full.
`timescale 1ns / 1ps
`default_nettype none

module row_bitmap_filter_engine import rbf_pkg::*; #(
   parameter int ROWS = ROWS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   cmd_type      fe_cmd, q_head;
   logic         push, pop, q_valid, q_full;
   back_sts_type sts;

   assign busy = q_full || sts.clearing;
   assign push = start && !busy;

   rbf_front #(.ROWS(ROWS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (push),
      .req_item (req_item),
      .cmd      (fe_cmd)
   );

   rbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (fe_cmd),
      .pop       (pop),
      .head      (q_head),
      .not_empty (q_valid),
      .full      (q_full)
   );

   rbf_back #(.ROWS(ROWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_head),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .sts       (sts)
   );

`ifndef SYNTHESIS
   ap_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full) else $error("item pushed into a full queue");
   ap_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      sts.clearing |-> !rsp_valid) else $error("result during clearing pass");
   ap_chunk_pace: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.final_result |-> ##2 rsp_valid)
      else $error("chunk stream broken");
   ap_chunk_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.final_result |-> sts.scanning)
      else $error("non-final result outside a scan");
   ap_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != ST_OK) |-> rsp_item.final_result)
      else $error("error result not final");
`endif

endmodule

`default_nettype wire

@@ tb/row_bitmap_filter_engine_tb.sv @@
// Self-checking testbench of the row bitmap filter engine: directed items, then
// random item sequences, checked against a behavioural bitmap model in a scoreboard.
// Depends on rbf_pkg and row_bitmap_filter_engine.
`timescale 1ns / 1ps

import rbf_pkg::*;

class bitmap_scoreboard;
   logic [63:0] words [64];
   int unsigned in_use;
   bit hint;
   rsp_type pending [$];
   int errors;

   function void clear();
      foreach (words[i]) words[i] = '0;
      in_use = 0;
      hint = 0;
      errors = 0;
   endfunction

   function bit rd(int unsigned r);
      if (r >= 4096) return 0;
      return words[r >> 6][r & 63];
   endfunction

   function void wr(int unsigned r, bit v);
      if (r < 4096) words[r >> 6][r & 63] = v;
   endfunction

   function void push(logic [1:0] st, bit ans, logic [63:0] bits, int unsigned cs,
                      int unsigned cnt);
      rsp_type r;
      r.status = st;
      r.answer = ans;
      r.bits_out = bits;
      r.chunk_start = cs[11:0];
      r.ones_count = cnt[12:0];
      r.final_result = 1'b1;
      pending.push_back(r);
   endfunction

   // Works out the results of one accepted item and updates the model state.
   function void note_item(req_type q);
      int unsigned p, n, nch, c, base;
      bit ok, all;
      logic [63:0] w;
      rsp_type r;
      p = q.position;
      n = q.length;
      ok = (p + n <= in_use);
      if (q.func >= F_AND && q.func <= F_APPEND && n > 64) begin
         push(ST_RANGE, 0, 0, 0, 0);
         return;
      end
      case (q.func)
         F_INIT: begin
            if (n > 4096) push(ST_CAP, 0, 0, 0, 0);
            else begin
               for (int i = 0; i < 4096; i++) wr(i, i < n ? q.bit_value : 1'b0);
               in_use = n;
               hint = q.bit_value;
               push(ST_OK, 0, 0, 0, 0);
            end
         end
         F_SET: begin
            if (p >= in_use) push(ST_RANGE, 0, 0, 0, 0);
            else begin
               wr(p, q.bit_value);
               push(ST_OK, 0, 0, 0, 0);
            end
         end
         F_FILL: begin
            if (!ok) push(ST_RANGE, 0, 0, 0, 0);
            else begin
               for (int i = 0; i < n; i++) wr(p + i, q.bit_value);
               push(ST_OK, 0, 0, 0, 0);
            end
         end
         F_GET: begin
            if (!ok) push(ST_RANGE, 0, 0, 0, 0);
            else begin
               all = 1;
               for (int i = 0; i < n; i++) if (!rd(p + i)) all = 0;
               nch = (n + 63) / 64;
               if (hint || all) push(ST_OK, 1, 0, p, 0);
               else if (nch > 64) push(ST_RANGE, 0, 0, 0, 0);
               else
                  for (int k = 0; k < nch; k++) begin
                     c = n - k * 64;
                     if (c > 64) c = 64;
                     w = '0;
                     for (int i = 0; i < c; i++) w[i] = rd(p + k * 64 + i);
                     push(ST_OK, 0, w, p + k * 64, 0);
                     pending[$].final_result = (k + 1 == nch);
                  end
            end
         end
         F_AND: begin
            if (!ok) push(ST_RANGE, 0, 0, 0, 0);
            else begin
               w = '0;
               for (int i = 0; i < n; i++) w[i] = q.data_word[i] & (hint | rd(p + i));
               push(ST_OK, 0, w, p, 0);
            end
         end
         F_MERGE, F_ISECT: begin
            if (!ok) push(ST_RANGE, 0, 0, 0, 0);
            else begin
               for (int i = 0; i < n; i++)
                  if (q.func == F_MERGE) begin
                     if (!hint) wr(p + i, rd(p + i) | q.data_word[i]);
                  end else
                     wr(p + i, hint ? q.data_word[i] : (rd(p + i) & q.data_word[i]));
               if (q.last_chunk)
                  hint = (q.func == F_MERGE) ? (hint | q.other_all_ones)
                                             : (hint & q.other_all_ones);
               push(ST_OK, 0, 0, p, 0);
            end
         end
         F_APPEND: begin
            base = in_use;
            if (base + n > 4096) push(ST_CAP, 0, 0, 0, 0);
            else begin
               for (int i = 0; i < n; i++) wr(base + i, q.data_word[i]);
               in_use = base + n;
               if (q.last_chunk) hint &= q.other_all_ones;
               push(ST_OK, 0, 0, base, 0);
            end
         end
         F_NONE: begin
            if (!ok) push(ST_RANGE, 0, 0, 0, 0);
            else begin
               all = 1;
               for (int i = 0; i < n; i++) if (rd(p + i)) all = 0;
               push(ST_OK, !hint && all, 0, 0, 0);
            end
         end
         F_COUNT: begin
            c = 0;
            for (int i = 0; i < in_use; i++) c += rd(i);
            push(ST_OK, 0, 0, 0, c);
         end
         F_OPT: begin
            all = 1;
            for (int i = 0; i < in_use; i++) if (!rd(i)) all = 0;
            hint = all;
            push(ST_OK, 0, 0, 0, 0);
         end
         default: push(ST_RANGE, 0, 0, 0, 0);
      endcase
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   task check_result(rsp_type r);
      rsp_type e;
      if (pending.size() == 0) begin
         report("unexpected item", r.bits_out, 0);
         return;
      end
      e = pending.pop_front();
      if (r.status !== e.status) report("status", r.status, e.status);
      if (r.answer !== e.answer) report("answer", r.answer, e.answer);
      if (r.bits_out !== e.bits_out) report("bits_out", r.bits_out, e.bits_out);
      if (r.chunk_start !== e.chunk_start)
         report("chunk_start", r.chunk_start, e.chunk_start);
      if (r.ones_count !== e.ones_count) report("ones_count", r.ones_count, e.ones_count);
      if (r.final_result !== e.final_result)
         report("final_result", r.final_result, e.final_result);
   endtask
endclass

module row_bitmap_filter_engine_tb;
   import rbf_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_item = '0;
   logic rsp_valid;
   rsp_type rsp_item;
   bitmap_scoreboard bitmap_sb;
   int idle_cycles = 0;

   row_bitmap_filter_engine DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) bitmap_sb.check_result(rsp_item);
         if (idle_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Start stays high across a zero gap so that it is driven once per edge.
   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g != 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Presents one item and holds it until the block takes it.
   task automatic send_item(req_type q);
      start <= 1'b1;
      req_item <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      bitmap_sb.note_item(q);
      idle_gap();
   endtask

   task automatic send_op(logic [3:0] f, int p, int n, bit v, logic [63:0] d = '0,
                          bit oth = 0, bit lst = 0);
      req_type q;
      q.func = f;
      q.position = p[12:0];
      q.length = n[12:0];
      q.bit_value = v;
      q.data_word = d;
      q.other_all_ones = oth;
      q.last_chunk = lst;
      send_item(q);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (bitmap_sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      req_type q;
      int pos, len, tick;
      bitmap_sb = new();
      bitmap_sb.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, every operation and the special cases.
      send_op(F_COUNT, 0, 0, 0);
      send_op(F_OPT, 0, 0, 0);
      send_op(F_INIT, 0, 4097, 1);
      send_op(F_INIT, 0, 4096, 1);
      send_op(F_GET, 0, 4096, 0);
      send_op(F_SET, 4095, 0, 0);
      send_op(F_GET, 0, 4096, 0);
      send_op(F_INIT, 0, 4096, 0);
      send_op(F_SET, 4095, 0, 1);
      send_op(F_GET, 0, 4096, 0);
      send_op(F_GET, 0, 4097, 0);
      send_op(F_SET, 4096, 0, 1);
      send_op(F_FILL, 100, 300, 1);
      send_op(F_AND, 64, 65, 0, '1);
      send_op(F_AND, 90, 64, 0, '1);
      send_op(F_MERGE, 0, 64, 0, 64'hA5A5_5A5A_F0F0_0F0F, 1, 1);
      send_op(F_AND, 8000, 64, 0, '1);
      send_op(F_ISECT, 32, 64, 0, 64'h0123_4567_89AB_CDEF, 0, 1);
      send_op(F_APPEND, 0, 1, 1, 1, 1, 1);
      send_op(F_INIT, 0, 100, 0);
      send_op(F_APPEND, 8191, 64, 0, '1, 1, 1);
      send_op(F_NONE, 0, 164, 0);
      send_op(F_COUNT, 0, 0, 0);
      send_op(4'd15, 0, 0, 0);
      send_op(4'd11, 8191, 8191, 1, '1, 1, 1);
      drain();
      repeat (20) @(posedge clock);

      // Random part: mostly in-range chunk and range work on small bitmaps.
      for (int k = 0; k < 330; k++) begin
         if (k % 60 == 0)
            send_op(F_INIT, 0, ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(0, 400),
                    1'($urandom_range(0, 1)));
         q.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                               : 4'($urandom_range(1, 10));
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 64);
         pos = bitmap_sb.in_use > len ? $urandom_range(0, bitmap_sb.in_use - len) : 0;
         if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 8191);
         // For one in four reads and fills, keep the range inside the rows in use and so within the chunk limit.
         if ((q.func == F_GET || q.func == F_FILL || q.func == F_NONE)
             && $urandom_range(0, 3) == 0 && bitmap_sb.in_use > 0) begin
            len = $urandom_range(0, bitmap_sb.in_use);
            pos = $urandom_range(0, bitmap_sb.in_use - len);
         end
         q.position = pos[12:0];
         q.length = len[12:0];
         q.bit_value = 1'($urandom_range(0, 1));
         q.data_word = rand_word();
         q.other_all_ones = 1'($urandom_range(0, 1));
         q.last_chunk = 1'($urandom_range(0, 1));
         send_item(q);
         if (k == 150) drain();
      end

      start <= 1'b0;
      tick = 0;
      while (bitmap_sb.pending.size() != 0 && tick < 100000) begin
         @(posedge clock);
         tick++;
      end
      repeat (300) @(posedge clock);
      if (bitmap_sb.errors == 0 && bitmap_sb.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/rbf_pkg.sv
rtl/rbf_front.sv
rtl/rbf_queue.sv
rtl/rbf_back.sv
rtl/row_bitmap_filter_engine.sv
tb/row_bitmap_filter_engine_tb.sv
